@@ src/yz0_pkg.sv @@
// Shared constants and types of the Yaz0 stream decompressor.
package yz0_pkg;
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int BYTES_PER_RESULT = 8;

    localparam logic [31:0] MAGIC_0 = 32'h5961_7A30;
    localparam logic [31:0] MAGIC_1 = 32'h5961_7A31;
    localparam logic [3:0] HDR_LAST = 4'hF;
    localparam logic [8:0] LONG_LEN_BIAS = 9'h012;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_REF = 3'd2;
    localparam logic [2:0] ST_OVERRUN = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;

    typedef struct packed {
        logic en;
        logic [WIN_AW-1:0] addr;
        logic [7:0] data;
    } t_hist_wr;
endpackage

@@ src/yz0_hist_mem.sv @@
// History window: one write port, one registered read port.
module yz0_hist_mem (
    input  logic                      i_clk,
    input  yz0_pkg::t_hist_wr         i_wr,
    input  logic [yz0_pkg::WIN_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    logic [7:0] r_mem [yz0_pkg::WINDOW_DEPTH];
    logic [7:0] r_rd_data;

    // Write the decoded byte
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ src/yaz0_lz_stream_decompressor.sv @@
// Top level of the Yaz0 stream decompressor: decoder, copy engine and output register.
//  channel | signals                                         | dir
//  in      | i_in_valid o_in_ready i_in_byte i_end_of_stream | sink
//  out     | o_out_valid i_out_ready o_out_data o_out_count  | source
//          | o_last o_status o_total_size                    |
// Header, flag and token bytes are each taken in the input step; a literal then passes
// through the emit step to load the output register. A copy steps through a history read
// and a write-back for each byte, and through the emit step for each packet emitted. Stalls
// on the output hold the decoder in its emit step. Reset is synchronous; the history needs no clearing pass.
module yaz0_lz_stream_decompressor #(
    parameter int BYTES_PER_RESULT = yz0_pkg::BYTES_PER_RESULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_count,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [31:0] o_total_size
);
    localparam int AW = yz0_pkg::WIN_AW;
    localparam logic [3:0] PK_FULL = 4'(BYTES_PER_RESULT);

    localparam logic [1:0] S_IN = 2'd0;
    localparam logic [1:0] S_RD = 2'd1;
    localparam logic [1:0] S_WR = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_FLAG = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_TOKEN2 = 3'd3;
    localparam logic [2:0] PH_TOKEN3 = 3'd4;
    localparam logic [2:0] PH_DRAIN = 3'd5;

    logic [1:0]  r_state;
    logic [2:0]  r_phase;
    logic [3:0]  r_hidx;
    logic [31:0] r_magic, r_size, r_prod;
    logic [7:0]  r_flag, r_th, r_tl;
    logic [2:0]  r_fidx;
    logic [AW-1:0] r_ptr, r_src;
    logic [8:0]  r_len;
    logic        r_eos, r_fin, r_cont;
    logic [2:0]  r_stat;
    logic [63:0] r_pk_data;
    logic [3:0]  r_pk_cnt;
    logic        r_ovalid, r_olast;
    logic [63:0] r_odata;
    logic [3:0]  r_ocnt;
    logic [2:0]  r_ostat;
    logic [31:0] r_osize;

    logic        in_acc, slot_free;
    logic [7:0]  rd_data;
    yz0_pkg::t_hist_wr hist_wr;
    logic [31:0] n_magic, n_size, n_prod;
    logic [11:0] tok12;
    logic [8:0]  n_len, long_len;
    logic [3:0]  n_pk_cnt;
    logic [32:0] copy_end;
    logic        flag_bit;

    assign o_in_ready = (r_state == S_IN);
    assign in_acc = i_in_valid && o_in_ready;
    assign slot_free = !r_ovalid || i_out_ready;

    assign n_magic = (r_hidx < 4'd4) ? {r_magic[23:0], i_in_byte} : r_magic;
    assign n_size = (r_hidx >= 4'd4 && r_hidx < 4'd8) ? {r_size[23:0], i_in_byte} : r_size;
    assign n_prod = r_prod + 32'd1;
    assign tok12 = {r_th[3:0], (r_phase == PH_TOKEN2) ? i_in_byte : r_tl};
    assign long_len = {1'b0, i_in_byte} + yz0_pkg::LONG_LEN_BIAS;
    assign n_len = (r_phase == PH_TOKEN3) ? long_len : {5'd0, r_th[7:4]} + 9'd2;
    assign copy_end = {1'b0, r_prod} + {24'd0, n_len};
    assign flag_bit = r_flag[3'd7 - r_fidx];
    assign n_pk_cnt = r_pk_cnt + 4'd1;

    // Steer history writes: literal at input accept, copied byte on read return
    always_comb begin
        hist_wr.en = 1'b0;
        hist_wr.addr = r_ptr;
        hist_wr.data = rd_data;
        if (r_state == S_WR) begin
            hist_wr.en = 1'b1;
        end else if (in_acc && r_phase == PH_DATA && flag_bit) begin
            hist_wr.en = 1'b1;
            hist_wr.data = i_in_byte;
        end
    end

    yz0_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd_addr (r_src),
        .o_rd_data (rd_data)
    );

    // Decode control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_phase <= PH_HEADER;
            r_hidx <= '0;
            r_magic <= '0;
            r_size <= '0;
            r_prod <= '0;
            r_flag <= '0;
            r_fidx <= '0;
            r_th <= '0;
            r_tl <= '0;
            r_ptr <= '0;
            r_src <= '0;
            r_len <= '0;
            r_eos <= 1'b0;
            r_fin <= 1'b0;
            r_cont <= 1'b0;
            r_stat <= yz0_pkg::ST_OK;
            r_pk_data <= '0;
            r_pk_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IN: begin
                    if (in_acc) begin
                        r_eos <= i_end_of_stream;
                        r_fin <= 1'b0;
                        r_cont <= 1'b0;
                        r_stat <= yz0_pkg::ST_OK;
                        r_pk_data <= '0;
                        r_pk_cnt <= '0;
                        unique case (r_phase)
                            PH_HEADER: begin
                                r_magic <= n_magic;
                                r_size <= n_size;
                                priority if (r_hidx != yz0_pkg::HDR_LAST && i_end_of_stream) begin
                                    r_fin <= 1'b1;
                                    r_stat <= yz0_pkg::ST_TRUNC;
                                    r_state <= S_EMIT;
                                end else if (r_hidx == 4'd3 && n_magic != yz0_pkg::MAGIC_0
                                             && n_magic != yz0_pkg::MAGIC_1) begin
                                    r_fin <= 1'b1;
                                    r_stat <= yz0_pkg::ST_BAD_MAGIC;
                                    r_state <= S_EMIT;
                                end else if (r_hidx == yz0_pkg::HDR_LAST) begin
                                    if (n_size == 32'd0) begin
                                        r_fin <= 1'b1;
                                        r_state <= S_EMIT;
                                    end else if (i_end_of_stream) begin
                                        r_fin <= 1'b1;
                                        r_stat <= yz0_pkg::ST_TRUNC;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_phase <= PH_FLAG;
                                        r_fidx <= '0;
                                    end
                                end else begin
                                    r_hidx <= r_hidx + 4'd1;
                                end
                            end
                            PH_FLAG: begin
                                r_flag <= i_in_byte;
                                if (i_end_of_stream) begin
                                    r_fin <= 1'b1;
                                    r_stat <= yz0_pkg::ST_TRUNC;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_phase <= PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (flag_bit) begin
                                    // Literal: emit one byte, then close the item
                                    r_ptr <= r_ptr + 1'b1;
                                    r_prod <= n_prod;
                                    r_pk_data <= {56'd0, i_in_byte};
                                    r_pk_cnt <= 4'd1;
                                    r_state <= S_EMIT;
                                    if (n_prod == r_size) begin
                                        r_fin <= 1'b1;
                                    end else if (i_end_of_stream) begin
                                        r_fin <= 1'b1;
                                        r_stat <= yz0_pkg::ST_TRUNC;
                                    end else begin
                                        r_fidx <= r_fidx + 3'd1;
                                        r_phase <= (r_fidx == 3'd7) ? PH_FLAG : PH_DATA;
                                    end
                                end else begin
                                    r_th <= i_in_byte;
                                    if (i_end_of_stream) begin
                                        r_fin <= 1'b1;
                                        r_stat <= yz0_pkg::ST_TRUNC;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_phase <= PH_TOKEN2;
                                    end
                                end
                            end
                            PH_TOKEN2, PH_TOKEN3: begin
                                if (r_phase == PH_TOKEN2) begin
                                    r_tl <= i_in_byte;
                                end
                                // Check distance, then length source, then overrun
                                priority if (r_phase == PH_TOKEN2 && {20'd0, tok12} >= r_prod) begin
                                    r_fin <= 1'b1;
                                    r_stat <= yz0_pkg::ST_BAD_REF;
                                    r_state <= S_EMIT;
                                end else if (r_phase == PH_TOKEN2 && r_th[7:4] == 4'd0) begin
                                    if (i_end_of_stream) begin
                                        r_fin <= 1'b1;
                                        r_stat <= yz0_pkg::ST_TRUNC;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_phase <= PH_TOKEN3;
                                    end
                                end else if (copy_end > {1'b0, r_size}) begin
                                    r_fin <= 1'b1;
                                    r_stat <= yz0_pkg::ST_OVERRUN;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_len <= n_len;
                                    r_src <= r_ptr - AW'(tok12) - 1'b1;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (i_end_of_stream) begin
                                    r_phase <= PH_HEADER;
                                    r_hidx <= '0;
                                    r_magic <= '0;
                                    r_size <= '0;
                                    r_prod <= '0;
                                    r_flag <= '0;
                                    r_fidx <= '0;
                                    r_th <= '0;
                                    r_tl <= '0;
                                    r_ptr <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    // Append copied byte and advance pointers
                    r_pk_data[8*r_pk_cnt[2:0] +: 8] <= rd_data;
                    r_pk_cnt <= n_pk_cnt;
                    r_ptr <= r_ptr + 1'b1;
                    r_src <= r_src + 1'b1;
                    r_prod <= n_prod;
                    r_len <= r_len - 9'd1;
                    if (r_len == 9'd1) begin
                        r_cont <= 1'b0;
                        r_state <= S_EMIT;
                        if (n_prod == r_size) begin
                            r_fin <= 1'b1;
                        end else if (r_eos) begin
                            r_fin <= 1'b1;
                            r_stat <= yz0_pkg::ST_TRUNC;
                        end else begin
                            r_fidx <= r_fidx + 3'd1;
                            r_phase <= (r_fidx == 3'd7) ? PH_FLAG : PH_DATA;
                        end
                    end else if (n_pk_cnt >= PK_FULL) begin
                        r_cont <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                default: begin
                    // Hand the packet to the output register when it frees
                    if (slot_free) begin
                        r_pk_data <= '0;
                        r_pk_cnt <= '0;
                        if (r_cont) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_IN;
                            if (r_fin && r_eos) begin
                                r_phase <= PH_HEADER;
                                r_hidx <= '0;
                                r_magic <= '0;
                                r_size <= '0;
                                r_prod <= '0;
                                r_flag <= '0;
                                r_fidx <= '0;
                                r_th <= '0;
                                r_tl <= '0;
                                r_ptr <= '0;
                            end else if (r_fin) begin
                                r_phase <= PH_DRAIN;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_EMIT && slot_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && slot_free) begin
            r_odata <= r_pk_data;
            r_ocnt <= r_pk_cnt;
            r_olast <= r_fin && !r_cont;
            r_ostat <= r_cont ? yz0_pkg::ST_OK : r_stat;
            r_osize <= r_size;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data = r_odata;
    assign o_out_count = r_ocnt;
    assign o_last = r_olast;
    assign o_status = r_ostat;
    assign o_total_size = r_osize;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_ocnt <= PK_FULL)
        else $error("packet exceeds result width");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != yz0_pkg::ST_OK) |-> r_olast)
        else $error("error status without last");
    a_copy_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_WR)
        else $error("history read not followed by write-back");
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |=> r_ptr == $past(r_ptr) + 1'b1)
        else $error("history pointer did not advance");
endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the Yaz0 stream decompressor, with its own decoder model.
`timescale 1ns / 1ps

module tb;
    typedef enum logic [2:0] {
        PH_HEADER, PH_FLAG, PH_DATA, PH_TOKEN2, PH_TOKEN3, PH_DRAIN
    } t_phase;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic [2:0]  status;
        logic [31:0] total;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_end_of_stream;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_data;
    logic [3:0]  o_out_count;
    logic        o_last;
    logic [2:0]  o_status;
    logic [31:0] o_total_size;

    yaz0_lz_stream_decompressor i_dut (.*);

    // Decoder model state
    t_phase      dec_phase;
    logic [3:0]  hdr_idx;
    logic [31:0] magic_acc;
    logic [31:0] size_decl;
    logic [31:0] size_done;
    logic [7:0]  flags;
    logic [2:0]  flag_pos;
    logic [7:0]  tok_hi;
    logic [7:0]  tok_lo;
    logic [7:0]  window [yz0_pkg::WINDOW_DEPTH];
    logic [11:0] win_ptr;
    logic [63:0] pkt_data;
    logic [3:0]  pkt_count;
    t_beat       step_beats[$];
    t_beat       pending_beats[$];

    int errors = 0;
    int out_wait = 0;
    bit no_idle = 0;

    // Clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic void push_beat(logic [63:0] d, logic [3:0] c);
        t_beat b;
        b.data = d; b.count = c; b.last = 1'b0; b.status = yz0_pkg::ST_OK;
        b.total = size_decl;
        step_beats.push_back(b);
    endfunction

    function automatic void flush_pkt();
        if (pkt_count != 0) begin
            push_beat(pkt_data, pkt_count);
            pkt_data = '0;
            pkt_count = '0;
        end
    endfunction

    function automatic void put_byte(logic [7:0] b);
        window[win_ptr] = b;
        win_ptr++;
        size_done++;
        pkt_data |= 64'(b) << (8 * pkt_count);
        pkt_count++;
        if (pkt_count == yz0_pkg::BYTES_PER_RESULT) flush_pkt();
    endfunction

    function automatic void clear_stream();
        dec_phase = PH_HEADER; hdr_idx = '0; magic_acc = '0; size_decl = '0;
        size_done = '0; flags = '0; flag_pos = '0; tok_hi = '0; tok_lo = '0;
        win_ptr = '0;
    endfunction

    function automatic void end_stream(logic [2:0] st, bit eos);
        flush_pkt();
        if (step_beats.size() == 0) push_beat('0, '0);
        step_beats[$].last = 1'b1;
        step_beats[$].status = st;
        if (eos) clear_stream();
        else dec_phase = PH_DRAIN;
    endfunction

    function automatic void next_item(bit eos);
        if (size_done == size_decl) end_stream(yz0_pkg::ST_OK, eos);
        else if (eos) end_stream(yz0_pkg::ST_TRUNC, eos);
        else begin
            flag_pos++;
            dec_phase = (flag_pos == 0) ? PH_FLAG : PH_DATA;
        end
    endfunction

    function automatic void copy_back(logic [12:0] back_dist, logic [8:0] len, bit eos);
        if (33'(size_done) + 33'(len) > 33'(size_decl)) begin
            end_stream(yz0_pkg::ST_OVERRUN, eos);
            return;
        end
        for (int j = 0; j < len; j++) put_byte(window[win_ptr - back_dist[11:0]]);
        flush_pkt();
        next_item(eos);
    endfunction

    // Work out the beats one accepted byte causes and queue them
    function automatic void decode_byte(logic [7:0] b, bit eos);
        logic [12:0] ref_dist;
        step_beats.delete();
        pkt_data = '0;
        pkt_count = '0;
        ref_dist = 13'({tok_hi[3:0], tok_lo}) + 13'd1;
        case (dec_phase)
            PH_HEADER: begin
                if (hdr_idx < 4) magic_acc = {magic_acc[23:0], b};
                else if (hdr_idx < 8) size_decl = {size_decl[23:0], b};
                if (hdr_idx < yz0_pkg::HDR_LAST && eos) end_stream(yz0_pkg::ST_TRUNC, eos);
                else if (hdr_idx == 3 && magic_acc != yz0_pkg::MAGIC_0
                         && magic_acc != yz0_pkg::MAGIC_1)
                    end_stream(yz0_pkg::ST_BAD_MAGIC, eos);
                else if (hdr_idx == yz0_pkg::HDR_LAST) begin
                    if (size_decl == 0) end_stream(yz0_pkg::ST_OK, eos);
                    else if (eos) end_stream(yz0_pkg::ST_TRUNC, eos);
                    else begin
                        dec_phase = PH_FLAG;
                        flag_pos = '0;
                    end
                end else hdr_idx++;
            end
            PH_FLAG: begin
                flags = b;
                if (eos) end_stream(yz0_pkg::ST_TRUNC, eos);
                else dec_phase = PH_DATA;
            end
            PH_DATA: begin
                if (flags[3'd7 - flag_pos]) begin
                    put_byte(b);
                    flush_pkt();
                    next_item(eos);
                end else begin
                    tok_hi = b;
                    if (eos) end_stream(yz0_pkg::ST_TRUNC, eos);
                    else dec_phase = PH_TOKEN2;
                end
            end
            PH_TOKEN2: begin
                tok_lo = b;
                ref_dist = 13'({tok_hi[3:0], tok_lo}) + 13'd1;
                if (32'(ref_dist) > size_done) end_stream(yz0_pkg::ST_BAD_REF, eos);
                else if (tok_hi[7:4] == 0) begin
                    if (eos) end_stream(yz0_pkg::ST_TRUNC, eos);
                    else dec_phase = PH_TOKEN3;
                end else copy_back(ref_dist, 9'(tok_hi[7:4]) + 9'd2, eos);
            end
            PH_TOKEN3: copy_back(ref_dist, 9'(b) + yz0_pkg::LONG_LEN_BIAS, eos);
            default: if (eos) clear_stream();
        endcase
        foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
    endfunction

    // Send one byte after a random gap and hold it until accepted
    task automatic send_byte(logic [7:0] b, bit eos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_byte(b, eos);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
    endtask

    // Build a stream: header, then groups of literals and references.
    // fault: 0 well formed, 1 cut short, 2 one corrupted byte, 3 size declared too small
    task automatic send_stream(int unsigned size, int fault, bit yaz1);
        logic [7:0]  bytes[$];
        logic [7:0]  items[$];
        logic [7:0]  flag;
        int unsigned made, rem, len, ref_dist, nb;
        int          fpos, cut;
        bytes = '{8'h59, 8'h61, 8'h7A, yaz1 ? 8'h31 : 8'h30,
                  size[31:24], size[23:16], size[15:8], size[7:0]};
        repeat (8) bytes.push_back(8'($urandom));
        made = 0;
        while (made < size) begin
            flag = '0;
            items.delete();
            for (int k = 7; k >= 0 && made < size; k--) begin
                rem = size - made;
                if (made == 0 || rem < 3 || $urandom_range(0, 1)) begin
                    flag[k] = 1'b1;
                    items.push_back(8'($urandom));
                    made++;
                end else begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 273)
                                                      : $urandom_range(3, 20);
                    if (len > rem) len = rem;
                    ref_dist = $urandom_range(1, made > 4096 ? 4096 : made);
                    if (len <= 17) begin
                        items.push_back({4'(len - 2), 4'((ref_dist - 1) >> 8)});
                        items.push_back(8'(ref_dist - 1));
                    end else begin
                        items.push_back({4'd0, 4'((ref_dist - 1) >> 8)});
                        items.push_back(8'(ref_dist - 1));
                        items.push_back(8'(len - 18));
                    end
                    made += len;
                end
            end
            bytes.push_back(flag);
            foreach (items[k]) bytes.push_back(items[k]);
        end
        if (fault == 3 && size > 0) begin
            nb = $urandom_range(1, size);
            bytes[6] = 8'((size - nb) >> 8);
            bytes[7] = 8'(size - nb);
            bytes[4] = 8'((size - nb) >> 24);
            bytes[5] = 8'((size - nb) >> 16);
        end
        if (fault == 2 && bytes.size() > 16)
            bytes[$urandom_range(16, bytes.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom));
        cut = bytes.size();
        if (fault == 1) cut = $urandom_range(1, bytes.size());
        for (fpos = 0; fpos < cut; fpos++) send_byte(bytes[fpos], fpos == cut - 1);
    endtask

    task automatic send_raw(logic [7:0] b[$]);
        foreach (b[k]) send_byte(b[k], k == b.size() - 1);
    endtask

    task automatic test_headers();
        send_stream(0, 0, 0);
        send_stream(0, 0, 1);
        send_raw('{8'h59, 8'h61, 8'h7A, 8'h32, 8'h00, 8'hFF});
        send_raw('{8'h00, 8'h00, 8'h00, 8'h00});
        send_raw('{8'h59, 8'h61, 8'h7A});
        send_raw('{8'hFF, 8'h9E, 8'h85, 8'hCF});
        send_raw('{8'h59, 8'h61, 8'h7A, 8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic test_tokens();
        logic [7:0] hdr[$];
        hdr = '{8'h59, 8'h61, 8'h7A, 8'h30, 8'h00, 8'h00, 8'h01, 8'h2C,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        // flag byte with end of stream
        send_raw({hdr, 8'hFF});
        // reference reaching before the start, distance 3072
        send_raw({hdr, 8'h7F, 8'hAB, 8'hFF, 8'hFF});
        // reference reaching before the start, ended on its second byte and with one more byte after it
        send_raw({hdr, 8'h7F, 8'h11, 8'h00});
        send_raw({hdr, 8'h7F, 8'h11, 8'h00, 8'h00});
        // longest copy, then a copy past the declared size
        send_raw({hdr, 8'hBF, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
        send_stream(300, 3, 1);
        send_stream(40, 1, 0);
    endtask

    task automatic test_random_streams(int n);
        int unsigned sz;
        int fault;
        for (int s = 0; s < n; s++) begin
            sz = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 600)
                                              : $urandom_range(1, 60);
            fault = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            no_idle = ($urandom_range(0, 5) == 0);
            send_stream(sz, fault, $urandom_range(0, 1));
        end
        no_idle = 0;
    endtask

    task automatic test_noise();
        logic [7:0] junk[$];
        junk = '{};
        repeat (40) junk.push_back(8'($urandom));
        send_raw(junk);
        // random declared size with a random tail, cut short
        junk = '{8'h59, 8'h61, 8'h7A, 8'h31};
        repeat (30) junk.push_back(8'($urandom));
        send_raw(junk);
    endtask

    // Output side: hold ready low for a random wait after each beat
    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            i_out_ready <= 1'b0;
            out_wait--;
        end else i_out_ready <= 1'b1;
    end

    // Compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_wait = no_idle ? 0 : $urandom_range(0, 5);
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: data %h count %0d", o_out_data, o_out_count);
                errors++;
            end else begin
                e = pending_beats.pop_front();
                if (o_out_data !== e.data) begin
                    $error("out_data exp %h got %h", e.data, o_out_data); errors++;
                end
                if (o_out_count !== e.count) begin
                    $error("out_count exp %0d got %0d", e.count, o_out_count); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_total_size !== e.total) begin
                    $error("total_size exp %h got %h", e.total, o_total_size); errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        i_end_of_stream = 1'b0;
        i_out_ready = 1'b0;
        clear_stream();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_headers();
        test_tokens();
        wait_drained();
        test_random_streams(4);
        wait_drained();
        test_noise();
        test_random_streams(4);
        wait_drained();
        repeat (50) @(negedge i_clk);
        if (pending_beats.size() != 0) begin
            $error("%0d beats never arrived", pending_beats.size());
            errors++;
        end
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ files.f @@
src/yz0_pkg.sv
src/yz0_hist_mem.sv
src/yaz0_lz_stream_decompressor.sv
tb/tb.sv
